// ----- hdl/spar_pkg.sv -----
// Package: types, tables and round functions for the SAFER+ Ar pipeline.
`timescale 1ns / 1ps
package spar_pkg;

  localparam int ROUNDS = 8;
  localparam int NKEYS  = 2 * ROUNDS + 1;

  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_AR_PRIME = 2'd2;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_word_t;

  typedef logic [15:0][7:0] state_t;

  // 45^x mod 257, mod 256
  function automatic logic [7:0] exp_f(input logic [7:0] x);
    logic [8:0] v;
    v = 9'd1;
    for (int i = 0; i < 256; i++) begin
      if (i[7:0] == x) return v[7:0];
      v = 9'((18'(v) * 18'd45) % 18'd257);
    end
    return v[7:0];
  endfunction

  function automatic logic [7:0] log_f(input logic [7:0] x);
    logic [8:0] v;
    v = 9'd1;
    for (int i = 0; i < 256; i++) begin
      if (v[7:0] == x) return 8'(i);
      v = 9'((18'(v) * 18'd45) % 18'd257);
    end
    return 8'd0;
  endfunction

  function automatic logic is_outer(input int j);
    return (j % 4 == 0) || (j % 4 == 3);
  endfunction

  function automatic state_t mix(input state_t s, input state_t k, input logic xor_outer);
    state_t t;
    for (int j = 0; j < 16; j++)
      t[j] = (is_outer(j) == xor_outer) ? (s[j] ^ k[j]) : 8'(s[j] + k[j]);
    return t;
  endfunction

  function automatic state_t sbox(input state_t s);
    state_t t;
    for (int j = 0; j < 16; j++)
      t[j] = is_outer(j) ? exp_f(s[j]) : log_f(s[j]);
    return t;
  endfunction

  function automatic state_t pht(input state_t s);
    state_t t;
    for (int j = 0; j < 16; j += 2) begin
      t[j]   = 8'({s[j], 1'b0} + s[j + 1]);
      t[j+1] = 8'(s[j] + s[j + 1]);
    end
    return t;
  endfunction

  function automatic state_t shuffle(input state_t s);
    localparam int P[16] = '{8, 11, 12, 15, 2, 1, 6, 5, 10, 9, 14, 13, 0, 7, 4, 3};
    state_t t;
    for (int j = 0; j < 16; j++) t[j] = s[P[j]];
    return t;
  endfunction

  function automatic state_t linear(input state_t s);
    return pht(shuffle(pht(shuffle(pht(shuffle(pht(s)))))));
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    int m;
    m = n % 8;
    return 8'((x << m) | (x >> ((8 - m) % 8)));
  endfunction

  // round key idx from the 17-byte key register (constant idx: bias is folded)
  function automatic state_t round_key(input int idx, input logic [16:0][7:0] reg17);
    state_t k;
    for (int j = 0; j < 16; j++) begin
      if (idx == 0) k[j] = reg17[j];
      else k[j] = 8'(rotl(reg17[(idx + j) % 17], 3 * idx) +
                      exp_f(exp_f(8'((17 * (idx + 1) + j + 1) % 256))));
    end
    return k;
  endfunction

endpackage

// ----- hdl/spar_round.sv -----
// One registered SAFER+ round in two halves: key/sbox/key, then the PHT network.
`timescale 1ns / 1ps
module spar_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                orig_en,
  input  logic                v_in,
  input  spar_pkg::state_t    s_in,
  input  spar_pkg::state_t    o_in,
  input  logic                ap_in,
  input  spar_pkg::state_t    k1,
  input  spar_pkg::state_t    k2,
  output logic                v_out,
  output spar_pkg::state_t    s_out,
  output spar_pkg::state_t    o_out,
  output logic                ap_out
);
  import spar_pkg::*;

  state_t a_r, a_nxt, s_r, o_a_r, o_r, pre;
  logic va_r, vb_r, apa_r, ap_r;

  // orig_en marks the round where Ar' folds the original block back in
  assign pre = (orig_en && ap_in) ? mix(s_in, o_in, 1'b1) : s_in;
  assign a_nxt = mix(sbox(mix(pre, k1, 1'b1)), k2, 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= v_in;
      vb_r <= va_r;
    end
    if (adv) begin
      a_r <= a_nxt; o_a_r <= o_in; apa_r <= ap_in;
      s_r <= linear(a_r); o_r <= o_a_r; ap_r <= apa_r;
    end
  end

  assign v_out  = vb_r;
  assign s_out  = s_r;
  assign o_out  = o_r;
  assign ap_out = ap_r;
endmodule

// ----- hdl/safer_plus_ar_block_cipher_top.sv -----
// Top level: SAFER+ Ar / Ar' encryption pipeline with key configuration.
`timescale 1ns / 1ps
// Usage
//   cfg_we/cfg_index/cfg_data load key_low (0), key_high (1) and the Ar'
//   select (2, bit 0). Write only while no word is in flight.
//   in_valid/in_stall carry a 128-bit plaintext word; out_valid/out_stall
//   return the ciphertext word in input order, one per input.
// Timing
//   Each round is two register stages (key mix, S-boxes and key mix, then the PHT
//   network); the final key mix feeds the output register. The pipeline
//   takes one word per cycle while the output is not stalled.
// Stall
//   The whole pipeline advances together; it freezes only when the output
//   register holds a word and out_stall is high. Nothing is dropped or
//   repeated, and in_stall mirrors that freeze.
// Reset
//   rst_n (synchronous) clears all valid bits and the key registers to zero.
module safer_plus_ar_block_cipher_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spar_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spar_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import spar_pkg::*;

  logic [63:0] key_lo_r, key_hi_r;
  logic        ap_r;
  logic [16:0][7:0] kreg;
  logic        adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0; key_hi_r <= '0; ap_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_lo_r <= cfg_data;
        CFG_KEY_HIGH: key_hi_r <= cfg_data;
        CFG_AR_PRIME: ap_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // key register with parity byte
  always_comb begin
    kreg[15:0] = {key_hi_r, key_lo_r};
    kreg[16] = '0;
    for (int j = 0; j < 16; j++) kreg[16] = kreg[16] ^ kreg[j];
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic   v   [ROUNDS+1];
  state_t s   [ROUNDS+1];
  state_t o   [ROUNDS+1];
  logic   ap  [ROUNDS+1];

  assign v[0]  = in_valid;
  assign s[0]  = {in_data.block_high, in_data.block_low};
  assign o[0]  = s[0];
  assign ap[0] = ap_r;

  // round keys per round, index fixed by the loop so the bias folds away
  for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
    state_t k1, k2;
    assign k1 = round_key(2 * r, kreg);
    assign k2 = round_key(2 * r + 1, kreg);
    spar_round u_rnd (
      .clk(clk), .rst_n(rst_n), .adv(adv), .orig_en(r == 2),
      .v_in(v[r]), .s_in(s[r]), .o_in(o[r]), .ap_in(ap[r]), .k1(k1), .k2(k2),
      .v_out(v[r+1]), .s_out(s[r+1]), .o_out(o[r+1]), .ap_out(ap[r+1])
    );
  end

  logic   ov_r;
  state_t os_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= v[ROUNDS];
    if (adv) os_r <= mix(s[ROUNDS], round_key(2 * ROUNDS, kreg), 1'b1);
  end

  assign out_valid            = ov_r;
  assign out_data.cipher_low  = os_r[7:0];
  assign out_data.cipher_high = os_r[15:8];
endmodule

// ----- hdl/spar_checker.sv -----
// Port-level checker for the SAFER+ pipeline, bound to the top level.
`timescale 1ns / 1ps
module spar_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spar_pkg::out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("stall with empty output");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input word withdrawn under stall");
endmodule

bind safer_plus_ar_block_cipher_top spar_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- dv/tb.sv -----
// Testbench for the SAFER+ Ar / Ar' cipher pipeline: random and directed words, scoreboarded.
`timescale 1ns / 1ps
module tb;
  import spar_pkg::*;

  localparam int LATENCY = 2 * ROUNDS + 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_KEY_LOW;
  logic [63:0] cfg_data = '0;

  int n_errors = 0;
  int n_words = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #10 clk = ~clk;

  safer_plus_ar_block_cipher_top u_top (.*);

  task automatic report(input string what);
    $display("ERROR at %0t: %s", $time, what);
    n_errors++;
  endtask

  // Cipher model and queue of expected ciphertext words.
  class cipher_board;
    logic [63:0] key_lo, key_hi;
    logic        ar_prime;
    logic [7:0]  exp_t[256];
    logic [7:0]  log_t[256];
    out_word_t   pending[$];

    function new();
      int v;
      v = 1;
      for (int i = 0; i < 256; i++) begin
        exp_t[i] = v[7:0];
        log_t[v[7:0]] = i[7:0];
        v = (v * 45) % 257;
      end
      key_lo = '0; key_hi = '0; ar_prime = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_KEY_LOW:  key_lo = val;
        CFG_KEY_HIGH: key_hi = val;
        CFG_AR_PRIME: ar_prime = val[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] rot3(logic [7:0] x, int n);
      int m;
      m = n % 8;
      if (m == 0) return x;
      return (x << m) | (x >> (8 - m));
    endfunction

    function bit outer_byte(int j);
      return (j % 4 == 0) || (j % 4 == 3);
    endfunction

    function void sub_key(int idx, logic [7:0] kr[17], output logic [7:0] k[16]);
      for (int j = 0; j < 16; j++)
        if (idx == 0) k[j] = kr[j];
        else k[j] = rot3(kr[(idx + j) % 17], 3 * idx)
                    + exp_t[exp_t[(17 * (idx + 1) + j + 1) % 256]];
    endfunction

    function void key_mix(ref logic [7:0] s[16], input logic [7:0] k[16], input bit xo);
      for (int j = 0; j < 16; j++)
        s[j] = (outer_byte(j) == xo) ? (s[j] ^ k[j]) : s[j] + k[j];
    endfunction

    function void pht_layer(ref logic [7:0] s[16]);
      logic [7:0] a, b;
      for (int j = 0; j < 16; j += 2) begin
        a = s[j]; b = s[j+1];
        s[j] = 2 * a + b;
        s[j+1] = a + b;
      end
    endfunction

    function void armenian(ref logic [7:0] s[16]);
      int perm[16] = '{8, 11, 12, 15, 2, 1, 6, 5, 10, 9, 14, 13, 0, 7, 4, 3};
      logic [7:0] t[16];
      for (int j = 0; j < 16; j++) t[j] = s[perm[j]];
      s = t;
    endfunction

    function void note_word(in_word_t w);
      logic [7:0] kr[17], orig[16], s[16], k1[16], k2[16];
      out_word_t  r;
      kr[16] = 8'h00;
      for (int j = 0; j < 8; j++) begin
        kr[j] = key_lo[8*j +: 8];
        kr[j+8] = key_hi[8*j +: 8];
        orig[j] = w.block_low[8*j +: 8];
        orig[j+8] = w.block_high[8*j +: 8];
      end
      for (int j = 0; j < 16; j++) kr[16] ^= kr[j];
      s = orig;
      for (int rd = 0; rd < ROUNDS; rd++) begin
        if (rd == 2 && ar_prime) key_mix(s, orig, 1'b1);
        sub_key(2 * rd, kr, k1);
        sub_key(2 * rd + 1, kr, k2);
        key_mix(s, k1, 1'b1);
        for (int j = 0; j < 16; j++) s[j] = outer_byte(j) ? exp_t[s[j]] : log_t[s[j]];
        key_mix(s, k2, 1'b0);
        pht_layer(s); armenian(s);
        pht_layer(s); armenian(s);
        pht_layer(s); armenian(s);
        pht_layer(s);
      end
      sub_key(2 * ROUNDS, kr, k1);
      key_mix(s, k1, 1'b1);
      for (int j = 0; j < 8; j++) begin
        r.cipher_low[8*j +: 8] = s[j];
        r.cipher_high[8*j +: 8] = s[j+8];
      end
      pending.push_back(r);
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.cipher_low !== want.cipher_low)
        report($sformatf("cipher_low %h, want %h", got.cipher_low, want.cipher_low));
      if (got.cipher_high !== want.cipher_high)
        report($sformatf("cipher_high %h, want %h", got.cipher_high, want.cipher_high));
    endtask
  endclass

  cipher_board board = new();

  // Output side: random stall, check on each accepted word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
      n_results++;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // Hold input until accepted; valid stays high between back-to-back words.
  task automatic send_word(input logic [63:0] lo, input logic [63:0] hi);
    in_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.block_low = lo;
    w.block_high = hi;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.note_word(w);
    n_words++;
  endtask

  // Let the pipe drain, then the latency margin, before touching config.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic rand_keys(input bit ext);
    if (ext) begin
      write_reg(CFG_KEY_LOW, $urandom_range(1) ? '1 : '0);
      write_reg(CFG_KEY_HIGH, $urandom_range(1) ? '1 : '0);
    end else begin
      write_reg(CFG_KEY_LOW, {$urandom, $urandom});
      write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
    end
    write_reg(CFG_AR_PRIME, {$urandom, $urandom});
  endtask

  initial begin
    logic [63:0] lo, hi;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme and patterned blocks under the reset key, then the all-ones key, each in both modes.
    send_word('0, '0);
    send_word('1, '1);
    send_word(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    drain();
    write_reg(CFG_AR_PRIME, 64'd1);
    send_word('0, '0);
    send_word('1, '1);
    drain();
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_HIGH, '1);
    for (int m = 0; m < 2; m++) begin
      write_reg(CFG_AR_PRIME, 64'(m));
      send_word('0, '0);
      send_word('1, '1);
      send_word(64'h8000000000000001, 64'h0123456789abcdef);
      drain();
    end
    // Parity byte non-zero: keys with odd byte xor.
    write_reg(CFG_KEY_LOW, 64'h0000000000000001);
    write_reg(CFG_KEY_HIGH, 64'h8000000000000000);
    write_reg(CFG_AR_PRIME, 64'hfffffffffffffffe);
    send_word('1, '0);
    send_word('0, '1);
    drain();

    // Random phases over the idling mixes, new keys per phase.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      rand_keys(ph == 7);
      for (int i = 0; i < 117; i++) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(15) == 0) lo = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(15) == 0) hi = $urandom_range(1) ? '1 : '0;
        send_word(lo, hi);
        // Pressure: pause until everything sent has come back.
        if (i == 60) begin
          in_valid <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d words over 8 key settings in Ar and Ar' modes;", n_words);
    $display("%0d ciphertext words checked under varied sender/receiver idling.", n_results);
    if (n_errors == 0 && board.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spar_pkg.sv
hdl/spar_round.sv
hdl/safer_plus_ar_block_cipher_top.sv
hdl/spar_checker.sv
dv/tb.sv
